// ===== sv/rarm_pkg.sv =====
// Shared types and codes for the range add / range membership block.
package rarm_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_BLK,
      S_BLKD,
      S_ERD,
      S_EDAT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic elem_rd;
      logic elem_wr;
      logic pend_rd;
      logic pend_wr;
   } mem_cmd_type;

endpackage

// ===== sv/rarm_store.sv =====
// Element memory and per-block pending-add memory, both with registered reads.
module rarm_store #(
   parameter int DEPTH = 4096,
   parameter int BLOCK = 64
) (
   input  logic                  clock,
   input  rarm_pkg::mem_cmd_type cmd,
   input  logic [$clog2(DEPTH)-1:0] elem_addr,
   input  logic [31:0]           elem_wdata,
   output logic [31:0]           elem_rdata,
   input  logic [(((DEPTH+BLOCK-1)/BLOCK) > 1 ? $clog2((DEPTH+BLOCK-1)/BLOCK) : 1)-1:0]
                                 pend_addr,
   input  logic [31:0]           pend_wdata,
   output logic [31:0]           pend_rdata
);
   import rarm_pkg::*;

   localparam int NBLK = (DEPTH + BLOCK - 1) / BLOCK;

   logic [31:0] elem_mem [DEPTH];
   logic [31:0] pend_mem [NBLK];
   logic [31:0] elem_rdata_ff;
   logic [31:0] pend_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.elem_wr) begin
         elem_mem[elem_addr] <= elem_wdata;
      end
      if (cmd.elem_rd) begin
         elem_rdata_ff <= elem_mem[elem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_wr) begin
         pend_mem[pend_addr] <= pend_wdata;
      end
      if (cmd.pend_rd) begin
         pend_rdata_ff <= pend_mem[pend_addr];
      end
   end

   assign elem_rdata = elem_rdata_ff;
   assign pend_rdata = pend_rdata_ff;

endmodule

// ===== sv/rarm_ctrl.sv =====
// Sequencer: clears the stores, walks ranges block by block and element by element.
module rarm_ctrl #(
   parameter int DEPTH = 4096,
   parameter int BLOCK = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [11:0]           req_left,
   input  logic [12:0]           req_right,
   input  logic signed [31:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output rarm_pkg::mem_cmd_type cmd,
   output logic [$clog2(DEPTH)-1:0] elem_addr,
   output logic [31:0]           elem_wdata,
   input  logic [31:0]           elem_rdata,
   output logic [(((DEPTH+BLOCK-1)/BLOCK) > 1 ? $clog2((DEPTH+BLOCK-1)/BLOCK) : 1)-1:0]
                                 pend_addr,
   output logic [31:0]           pend_wdata,
   input  logic [31:0]           pend_rdata
);
   import rarm_pkg::*;

   localparam int NBLK = (DEPTH + BLOCK - 1) / BLOCK;
   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = AW + 1;
   localparam int BW   = (NBLK > 1) ? $clog2(NBLK) : 1;
   localparam int XW   = (CW > 13) ? CW + 1 : 14;

   state_type        state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [CW-1:0]    l_ff, l_in;
   logic [CW-1:0]    r_ff, r_in;
   logic [CW-1:0]    bstart_ff, bstart_in;
   logic [CW-1:0]    bend_ff, bend_in;
   logic [BW-1:0]    blk_ff, blk_in;
   logic [31:0]      v_ff, v_in;
   logic [31:0]      pend_ff, pend_in;
   logic             found_ff, found_in;
   logic [CW-1:0]    clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;

   logic [XW-1:0]    lw, rw, rs, blk_w, bstart_w, bend_w, nb_w, nb_end;
   logic             whole, last, hit, blk_edge;

   // range setup for an incoming transfer
   always_comb begin
      lw       = XW'(req_left);
      rw       = XW'(req_right);
      rs       = (rw > XW'(DEPTH)) ? XW'(DEPTH) : rw;
      blk_w    = XW'(lw / BLOCK);
      bstart_w = XW'(blk_w * XW'(BLOCK));
      bend_w   = bstart_w + XW'(BLOCK);
      if (bend_w > XW'(DEPTH)) begin
         bend_w = XW'(DEPTH);
      end
      nb_w     = XW'(bend_ff) + XW'(BLOCK);
      nb_end   = (nb_w > XW'(DEPTH)) ? XW'(DEPTH) : nb_w;
   end

   assign whole    = (bstart_ff >= l_ff) && (bend_ff <= r_ff);
   assign last     = (j_ff + CW'(1)) >= r_ff;
   assign blk_edge = (j_ff + CW'(1)) == bend_ff;
   assign hit      = (elem_rdata + pend_ff) == v_ff;

   // next state and register updates
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      j_in         = j_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      bstart_in    = bstart_ff;
      bend_in      = bend_ff;
      blk_in       = blk_ff;
      v_in         = v_ff;
      pend_in      = pend_ff;
      found_in     = found_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_opcode;
               v_in      = req_value;
               l_in      = CW'(lw);
               j_in      = CW'(lw);
               r_in      = CW'(rs);
               blk_in    = BW'(blk_w);
               bstart_in = CW'(bstart_w);
               bend_in   = CW'(bend_w);
               found_in  = 1'b0;
               case (req_opcode)
                  OP_LOAD: begin
                     if (lw < XW'(DEPTH)) begin
                        state_in = S_BLK;
                     end
                  end
                  OP_ADD: begin
                     if (lw < rs) begin
                        state_in = S_BLK;
                     end
                  end
                  OP_QUERY: begin
                     state_in = (lw < rs) ? S_BLK : S_RESP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_BLK: begin
            state_in = S_BLKD;
         end
         S_BLKD: begin
            pend_in = pend_rdata;
            if (op_ff == OP_LOAD) begin
               state_in = S_IDLE;
            end else if (op_ff == OP_ADD && whole) begin
               if (bend_ff >= r_ff) begin
                  state_in = S_IDLE;
               end else begin
                  blk_in    = blk_ff + BW'(1);
                  bstart_in = bend_ff;
                  bend_in   = CW'(nb_end);
                  j_in      = bend_ff;
                  state_in  = S_BLK;
               end
            end else begin
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            state_in = S_EDAT;
         end
         S_EDAT: begin
            if (op_ff == OP_QUERY && (hit || last)) begin
               found_in = hit;
               state_in = S_RESP;
            end else if (last) begin
               state_in = S_IDLE;
            end else begin
               j_in = j_ff + CW'(1);
               if (blk_edge) begin
                  blk_in    = blk_ff + BW'(1);
                  bstart_in = bend_ff;
                  bend_in   = CW'(nb_end);
                  state_in  = S_BLK;
               end else begin
                  state_in = S_ERD;
               end
            end
         end
         S_RESP: begin
            // hold the answer until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory commands
   always_comb begin
      cmd        = '0;
      elem_addr  = AW'(j_ff);
      elem_wdata = elem_rdata + v_ff;
      pend_addr  = blk_ff;
      pend_wdata = pend_rdata + v_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.elem_wr = 1'b1;
            elem_addr   = AW'(clr_ff);
            elem_wdata  = '0;
            cmd.pend_wr = clr_ff < CW'(NBLK);
            pend_addr   = BW'(clr_ff);
            pend_wdata  = '0;
         end
         S_BLK: begin
            cmd.pend_rd = 1'b1;
         end
         S_BLKD: begin
            if (op_ff == OP_LOAD) begin
               cmd.elem_wr = 1'b1;
               elem_addr   = AW'(l_ff);
               elem_wdata  = v_ff - pend_rdata;
            end else if (op_ff == OP_ADD && whole) begin
               cmd.pend_wr = 1'b1;
            end
         end
         S_ERD: begin
            cmd.elem_rd = 1'b1;
         end
         S_EDAT: begin
            cmd.elem_wr = (op_ff == OP_ADD);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      j_ff         <= j_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      bstart_ff    <= bstart_in;
      bend_ff      <= bend_in;
      blk_ff       <= blk_in;
      v_ff         <= v_in;
      pend_ff      <= pend_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EDAT |-> j_ff < r_ff)
      else $error("element scan past range end");

   a_scan_in_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ERD |-> (j_ff >= bstart_ff) && (j_ff < bend_ff))
      else $error("element scan outside current block");

   a_resp_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("query answer not presented");

endmodule

// ===== sv/range_add_range_membership.sv =====
// Top level: range add and range membership over a block-split array.
//
// Channels: req_* carries one item (opcode, left, right, value) and is taken
// when req_valid is high and req_stall low. rsp_* carries one found bit for
// each query; opcode 0 (load), opcode 1 (add) and opcode 3 give no response.
// Elements live in one memory, per-block pending adds in a second; both have
// a registered read. Whole blocks of an add touch only the pending add.
// A load takes the item, reads its block's pending add, then writes the value
// less that add. An add takes the item, reads each touched block's pending
// add and updates it for whole blocks, reading and writing each element of a
// partly covered block. A query takes the item, reads each block's pending
// add and reads elements (whole blocks included) up to the first match, then
// loads the response register. One item is worked on at a time; req_stall is
// high while it runs. Reset: a clearing pass over every element address zeroes
// both memories; req_stall stays high during it.
// A stalled response stays in its output register; a finished query waits
// for that register before the next item is taken.
module range_add_range_membership #(
   parameter int DEPTH = 4096,
   parameter int BLOCK = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [11:0]        req_left,
   input  logic [12:0]        req_right,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found
);
   import rarm_pkg::*;

   localparam int NBLK = (DEPTH + BLOCK - 1) / BLOCK;
   localparam int AW   = $clog2(DEPTH);
   localparam int BW   = (NBLK > 1) ? $clog2(NBLK) : 1;

   mem_cmd_type  cmd;
   logic [AW-1:0] elem_addr;
   logic [31:0]   elem_wdata, elem_rdata;
   logic [BW-1:0] pend_addr;
   logic [31:0]   pend_wdata, pend_rdata;

   rarm_ctrl #(.DEPTH(DEPTH), .BLOCK(BLOCK)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_left   (req_left),
      .req_right  (req_right),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_found  (rsp_found),
      .cmd        (cmd),
      .elem_addr  (elem_addr),
      .elem_wdata (elem_wdata),
      .elem_rdata (elem_rdata),
      .pend_addr  (pend_addr),
      .pend_wdata (pend_wdata),
      .pend_rdata (pend_rdata)
   );

   rarm_store #(.DEPTH(DEPTH), .BLOCK(BLOCK)) u_store (
      .clock      (clock),
      .cmd        (cmd),
      .elem_addr  (elem_addr),
      .elem_wdata (elem_wdata),
      .elem_rdata (elem_rdata),
      .pend_addr  (pend_addr),
      .pend_wdata (pend_wdata),
      .pend_rdata (pend_rdata)
   );

endmodule

// ===== tb/range_add_range_membership_tb.sv =====
// Testbench for range_add_range_membership: table and random items against a predictor.
`timescale 1ns / 100ps

module range_add_range_membership_tb;
   import rarm_pkg::*;

   localparam int         DEPTH   = 4096;
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int         RANDOM_ITEMS = 1730;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = OP_LOAD;
   logic [11:0]        req_left = '0;
   logic [12:0]        req_right = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_found;

   range_add_range_membership dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_left(req_left), .req_right(req_right), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found)
   );

   always #4 clock = ~clock;

   // Predictor state: the true value of every element, pending adds already applied.
   logic [31:0] true_values [DEPTH];
   logic        found_queue [$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          n_load = 0, n_add = 0, n_query = 0, n_hits = 0, n_checked = 0;
   logic        hold_off = 1'b0;

   typedef struct {
      logic [1:0]  op;
      logic [11:0] left;
      logic [12:0] right;
      logic [31:0] value;
      int          expect_found;   // -1: take the predictor's answer
   } stim_row_type;

   task automatic predict_item(input logic [1:0] op, input logic [11:0] l,
                               input logic [12:0] r_in, input logic [31:0] v,
                               input int typed);
      int   r;
      logic hit;
      r = (r_in > DEPTH) ? DEPTH : r_in;
      hit = 1'b0;
      case (op)
         OP_LOAD: begin
            true_values[l] = v;
            n_load++;
         end
         OP_ADD: begin
            for (int j = l; j < r; j++) true_values[j] = true_values[j] + v;
            n_add++;
         end
         OP_QUERY: begin
            for (int j = l; j < r; j++) if (true_values[j] == v) hit = 1'b1;
            if (typed >= 0) hit = (typed != 0);
            found_queue.push_back(hit);
            n_query++;
         end
         default: ;
      endcase
   endtask

   // Hold the item until it transfers, then update the predictor.
   task automatic send_item(input logic [1:0] op, input logic [11:0] l,
                            input logic [12:0] r, input logic [31:0] v, input int typed);
      req_opcode <= op;
      req_left   <= l;
      req_right  <= r;
      req_value  <= v;
      req_valid  <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_item(op, l, r, v, typed);
      items_sent++;
   endtask

   int burst_left = 0;
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
         1, 2:    return $urandom;
         default: return $urandom_range(0, 6) - 3;
      endcase
   endfunction

   task automatic pick_range(output logic [11:0] l, output logic [12:0] r);
      int lo, len;
      lo = $urandom_range(0, DEPTH - 1);
      case ($urandom_range(0, 19))
         0, 1:  len = DEPTH;                        // ends at or past the end
         2:     len = -int'($urandom_range(0, 20)); // empty range
         3, 4: begin
            lo  = lo & ~63;                         // block aligned
            len = 64 * $urandom_range(1, 4);
         end
         5, 6, 7: len = $urandom_range(1, 300);
         default: len = $urandom_range(1, 80);
      endcase
      l = 12'(lo);
      if (len == DEPTH) r = 13'($urandom_range(DEPTH, 8191));
      else if (lo + len < 0) r = 0;
      else r = (lo + len > 8191) ? 13'd8191 : 13'(lo + len);
   endtask

   stim_row_type directed [] = '{
      '{OP_QUERY, 12'd0,    13'd4096, 32'd0,        1},
      '{OP_QUERY, 12'd0,    13'd4096, 32'd5,        0},
      '{OP_QUERY, 12'd10,   13'd10,   32'd0,        0},
      '{OP_QUERY, 12'd4095, 13'd4096, 32'd0,        1},
      '{OP_QUERY, 12'd100,  13'd8191, 32'd0,        1},
      '{OP_LOAD,  12'd0,    13'd0,    32'h7fffffff, -1},
      '{OP_LOAD,  12'd4095, 13'd8191, 32'h80000000, -1},
      '{OP_ADD,   12'd0,    13'd4096, 32'd1,        -1},
      '{OP_QUERY, 12'd0,    13'd1,    32'h80000000, -1},
      '{OP_QUERY, 12'd4095, 13'd4096, 32'h80000001, -1},
      '{OP_ADD,   12'd64,   13'd128,  32'hfffffffb, -1},
      '{OP_ADD,   12'd60,   13'd70,   32'd7,        -1},
      '{OP_QUERY, 12'd64,   13'd128,  32'hfffffffc, -1},
      '{OP_QUERY, 12'd60,   13'd70,   32'd8,        -1},
      '{OP_QUERY, 12'd66,   13'd127,  32'd3,        -1},
      '{OP_NONE,  12'd0,    13'd4096, 32'd9,        -1},
      '{OP_ADD,   12'd100,  13'd50,   32'd9,        -1},
      '{OP_QUERY, 12'd0,    13'd4096, 32'd1,        -1},
      '{OP_ADD,   12'd4032, 13'd8191, 32'd3,        -1},
      '{OP_QUERY, 12'd4000, 13'd4096, 32'd4,        -1},
      '{OP_LOAD,  12'd127,  13'd5,    32'hffffffff, -1},
      '{OP_QUERY, 12'd64,   13'd200,  32'hffffffff, -1}
   };

   initial begin
      logic [1:0]  op;
      logic [11:0] l;
      logic [12:0] r;
      int          k;
      foreach (true_values[j]) true_values[j] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i])
         send_item(directed[i].op, directed[i].left, directed[i].right,
                   directed[i].value, directed[i].expect_found);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pace_sender();
         k = $urandom_range(0, 19);
         op = (k < 5) ? OP_LOAD : (k < 11) ? OP_ADD : (k < 19) ? OP_QUERY : OP_NONE;
         pick_range(l, r);
         send_item(op, l, r, pick_value(), -1);
      end
      req_valid <= 1'b0;
      while (found_queue.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("Covered %0d loads, %0d range adds and %0d queries (%0d checked, %0d found).",
               n_load, n_add, n_query, n_checked, n_hits);
      if (mismatches == 0 && found_queue.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d errors, %0d responses outstanding", mismatches, found_queue.size());
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver: stall density changes in phases; hold_off forces a long stall.
   int stall_pct = 0, phase_left = 0;
   always @(posedge clock) begin
      if (phase_left == 0) begin
         phase_left = $urandom_range(20, 200);
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 30;
            2:       stall_pct = 70;
            default: stall_pct = 10;
         endcase
      end
      phase_left--;
      rsp_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      wait (items_sent >= 600);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (500) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      logic exp_found;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (found_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response, found=%0b", rsp_found);
         end else begin
            exp_found = found_queue.pop_front();
            n_checked++;
            if (exp_found) n_hits++;
            if (rsp_found !== exp_found) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Query response %0d: found expected %0b, got %0b",
                           n_checked, exp_found, rsp_found);
            end
         end
      end
   end

   // Full-range queries can scan every element; allow for all of them.
   initial begin
      #600_000_000;
      $display("Timeout waiting for the block");
      $display("Mismatches found");
      $finish;
   end

endmodule
